### sv/vmlc_pkg.sv
// ----------------------------------------------------------------------------
// vmlc_pkg
// Shared types and constants for the valve motor limit controller.
// ----------------------------------------------------------------------------
package vmlc_pkg;

	// Command codes carried in func
	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_OPEN    = 2'd1;
	localparam logic [1:0] FUNC_CLOSE   = 2'd2;
	localparam logic [1:0] FUNC_PARTIAL = 2'd3;

	// Register indexes on the configuration port
	localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
	localparam logic [1:0] CFG_DEBOUNCE = 2'd1;
	localparam logic [1:0] CFG_WAKE     = 2'd2;
	localparam logic [1:0] CFG_PAUSE    = 2'd3;

	// Register reset values
	localparam logic [15:0] TIMEOUT_RST  = 16'd15000;
	localparam logic [7:0]  DEBOUNCE_RST = 8'd20;
	localparam logic [7:0]  WAKE_RST     = 8'd10;
	localparam logic [9:0]  PAUSE_RST    = 10'd250;

	// Outcome codes
	localparam logic [1:0] OUT_OK        = 2'd0;
	localparam logic [1:0] OUT_TIMEOUT   = 2'd1;
	localparam logic [1:0] OUT_OPEN_HIT  = 2'd2;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [7:0]  debounce_ms;
		logic [7:0]  wake_ms;
		logic [9:0]  pause_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  func;
		logic        open_switch_level;
		logic        closed_switch_level;
		logic [15:0] partial_ms;
	} item_t;

	typedef struct packed {
		logic       driver_awake;
		logic       drive_open;
		logic       drive_close;
		logic       busy_res;
		logic       done_res;
		logic [1:0] outcome;
	} result_t;

endpackage

### sv/vmlc_cfg_regs.sv
// ----------------------------------------------------------------------------
// vmlc_cfg_regs
// Configuration register file: timeout, debounce, wake and pause times.
// ----------------------------------------------------------------------------
module vmlc_cfg_regs import vmlc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// Write decode, one register per index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms  <= TIMEOUT_RST;
			cfg_q.debounce_ms <= DEBOUNCE_RST;
			cfg_q.wake_ms     <= WAKE_RST;
			cfg_q.pause_ms    <= PAUSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMEOUT:  cfg_q.timeout_ms  <= cfg_wdata;
				CFG_DEBOUNCE: cfg_q.debounce_ms <= cfg_wdata[7:0];
				CFG_WAKE:     cfg_q.wake_ms     <= cfg_wdata[7:0];
				CFG_PAUSE:    cfg_q.pause_ms    <= cfg_wdata[9:0];
				default:      ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/vmlc_ctrl.sv
// ----------------------------------------------------------------------------
// vmlc_ctrl
// Valve sequencer: phase state plus the one-pass update for each transaction.
// ----------------------------------------------------------------------------
module vmlc_ctrl import vmlc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_CHECK_OPEN  = 4'd1,
		PH_CHECK_CLOSE = 4'd2,
		PH_WAKE_OPEN   = 4'd3,
		PH_WAKE_CLOSE  = 4'd4,
		PH_DRIVE_OPEN  = 4'd5,
		PH_DRIVE_CLOSE = 4'd6,
		PH_PAUSE       = 4'd7,
		PH_PWAKE       = 4'd8,
		PH_PDRIVE      = 4'd9
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] timer;
		logic [7:0]  deb;
		logic        pend;
		logic [15:0] plen;
		logic [1:0]  outc;
		logic        fin;
	} st_t;

	st_t st_q;
	st_t st_d;

	function automatic st_t do_finish(st_t s, logic [1:0] code);
		st_t r;
		r       = s;
		r.phase = PH_IDLE;
		r.timer = '0;
		r.deb   = '0;
		r.pend  = 1'b0;
		r.outc  = code;
		r.fin   = 1'b1;
		return r;
	endfunction

	function automatic st_t enter_drive(st_t s, logic to_open);
		st_t r;
		r       = s;
		r.phase = to_open ? PH_DRIVE_OPEN : PH_DRIVE_CLOSE;
		r.timer = '0;
		r.deb   = '0;
		return r;
	endfunction

	function automatic st_t enter_wake(st_t s, logic to_open, cfg_t c);
		st_t r;
		r       = s;
		r.phase = to_open ? PH_WAKE_OPEN : PH_WAKE_CLOSE;
		r.timer = '0;
		r.deb   = '0;
		if (c.wake_ms == '0) r = enter_drive(r, to_open);
		return r;
	endfunction

	function automatic st_t enter_pdrive(st_t s);
		st_t r;
		r       = s;
		r.phase = PH_PDRIVE;
		r.timer = '0;
		r.deb   = '0;
		if (r.plen == '0) r = do_finish(r, OUT_OK);
		return r;
	endfunction

	function automatic st_t enter_pwake(st_t s, cfg_t c);
		st_t r;
		r       = s;
		r.phase = PH_PWAKE;
		r.timer = '0;
		if (c.wake_ms == '0) r = enter_pdrive(r);
		return r;
	endfunction

	function automatic st_t enter_pause(st_t s, cfg_t c);
		st_t r;
		r       = s;
		r.phase = PH_PAUSE;
		r.timer = '0;
		r.deb   = '0;
		if (c.pause_ms == '0) r = enter_pwake(r, c);
		return r;
	endfunction

	function automatic st_t close_success(st_t s, cfg_t c);
		st_t r;
		if (s.pend) r = enter_pause(s, c);
		else        r = do_finish(s, OUT_OK);
		return r;
	endfunction

	// Saturating counter steps and active-low switch decode
	logic        open_act;
	logic        closed_act;
	logic [15:0] timer_inc;
	logic [7:0]  deb_inc;
	logic        to_open;
	logic        tgt_act;
	logic [7:0]  deb_nxt;
	logic        deb_hit;

	assign open_act   = ~item.open_switch_level;
	assign closed_act = ~item.closed_switch_level;
	assign timer_inc  = (st_q.timer == 16'hFFFF) ? st_q.timer : st_q.timer + 16'd1;
	assign deb_inc    = (st_q.deb == 8'hFF) ? st_q.deb : st_q.deb + 8'd1;

	// Direction and target switch of the current phase
	assign to_open = (st_q.phase == PH_CHECK_OPEN) || (st_q.phase == PH_WAKE_OPEN) ||
		(st_q.phase == PH_DRIVE_OPEN) || (st_q.phase == PH_PDRIVE);
	assign tgt_act = to_open ? open_act : closed_act;
	assign deb_nxt = tgt_act ? deb_inc : 8'd0;
	assign deb_hit = tgt_act && (deb_nxt >= cfg.debounce_ms);

	// Next state for one transaction
	always_comb begin
		st_d     = st_q;
		st_d.fin = 1'b0;
		if (item.func == FUNC_TICK) begin
			case (st_q.phase)
				PH_CHECK_OPEN, PH_CHECK_CLOSE: begin
					if (!tgt_act) begin
						st_d = enter_wake(st_d, to_open, cfg);
					end else begin
						st_d.deb = deb_nxt;
						if (deb_hit) begin
							if (to_open) st_d = do_finish(st_d, OUT_OK);
							else         st_d = close_success(st_d, cfg);
						end
					end
				end
				PH_WAKE_OPEN, PH_WAKE_CLOSE: begin
					st_d.timer = timer_inc;
					if (timer_inc >= {8'd0, cfg.wake_ms}) st_d = enter_drive(st_d, to_open);
				end
				PH_DRIVE_OPEN, PH_DRIVE_CLOSE: begin
					st_d.timer = timer_inc;
					st_d.deb   = deb_nxt;
					if (deb_hit) begin
						if (to_open) st_d = do_finish(st_d, OUT_OK);
						else         st_d = close_success(st_d, cfg);
					end else if (timer_inc >= cfg.timeout_ms) begin
						st_d = do_finish(st_d, OUT_TIMEOUT);
					end
				end
				PH_PAUSE: begin
					st_d.timer = timer_inc;
					if (timer_inc >= {6'd0, cfg.pause_ms}) st_d = enter_pwake(st_d, cfg);
				end
				PH_PWAKE: begin
					st_d.timer = timer_inc;
					if (timer_inc >= {8'd0, cfg.wake_ms}) st_d = enter_pdrive(st_d);
				end
				PH_PDRIVE: begin
					st_d.timer = timer_inc;
					st_d.deb   = deb_nxt;
					if (deb_hit)                        st_d = do_finish(st_d, OUT_OPEN_HIT);
					else if (timer_inc >= st_q.plen)    st_d = do_finish(st_d, OUT_OK);
				end
				default: st_d.phase = PH_IDLE;
			endcase
		end else if (st_q.phase == PH_IDLE) begin
			// New command; commands while busy are dropped
			st_d.timer = '0;
			st_d.deb   = '0;
			case (item.func)
				FUNC_OPEN: begin
					st_d.pend = 1'b0;
					if (open_act) st_d.phase = PH_CHECK_OPEN;
					else          st_d = enter_wake(st_d, 1'b1, cfg);
				end
				FUNC_CLOSE: begin
					st_d.pend = 1'b0;
					if (closed_act) st_d.phase = PH_CHECK_CLOSE;
					else            st_d = enter_wake(st_d, 1'b0, cfg);
				end
				default: begin
					st_d.pend = 1'b1;
					st_d.plen = item.partial_ms;
					if (closed_act) st_d.phase = PH_CHECK_CLOSE;
					else            st_d = enter_wake(st_d, 1'b0, cfg);
				end
			endcase
		end
	end

	// State register, advanced once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= PH_IDLE;
			st_q.timer <= '0;
			st_q.deb   <= '0;
			st_q.pend  <= 1'b0;
			st_q.plen  <= '0;
			st_q.outc  <= '0;
			st_q.fin   <= 1'b0;
		end else if (step) begin
			st_q <= st_d;
		end
	end

	// Bridge lines and status from the updated state
	always_comb begin
		res.driver_awake = (st_d.phase >= PH_WAKE_OPEN) && (st_d.phase != PH_PAUSE);
		res.drive_open   = (st_d.phase == PH_DRIVE_OPEN) || (st_d.phase == PH_PDRIVE);
		res.drive_close  = (st_d.phase == PH_DRIVE_CLOSE);
		res.busy_res     = (st_d.phase != PH_IDLE);
		res.done_res     = st_d.fin;
		res.outcome      = st_d.outc;
	end

endmodule

### sv/valve_motor_limit_controller_top.sv
// ----------------------------------------------------------------------------
// valve_motor_limit_controller_top
// DC-motor valve controller with limit switches, debounce and timeouts.
//
//   channel | signals                              | dir | notes
//   --------+--------------------------------------+-----+---------------------
//   in      | in_valid/in_ready, func, switches,   | in  | tick or command
//           | partial_ms                           |     |
//   out     | out_valid/out_ready, bridge lines,   | out | one per input
//           | busy_res, done_res, outcome          |     |
//   cfg     | cfg_we, cfg_index, cfg_wdata         | in  | write only
//
// One transaction per cycle sustained while out_ready stays high; the path runs
// through the input register, then the sequencer update into the result register.
// arst_n clears the sequencer to idle and loads the register defaults.
// A stalled out_ready holds the result register; in_ready drops only when
// both the input and result registers are full.
// ----------------------------------------------------------------------------
module valve_motor_limit_controller_top import vmlc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic        open_switch_level,
	input  logic        closed_switch_level,
	input  logic [15:0] partial_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        driver_awake,
	output logic        drive_open,
	output logic        drive_close,
	output logic        busy_res,
	output logic        done_res,
	output logic [1:0]  outcome,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	vmlc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Stage 1 moves on whenever the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.func                <= func;
			item_s1.open_switch_level   <= open_switch_level;
			item_s1.closed_switch_level <= closed_switch_level;
			item_s1.partial_ms          <= partial_ms;
		end
	end

	vmlc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign driver_awake = res_s2.driver_awake;
	assign drive_open   = res_s2.drive_open;
	assign drive_close  = res_s2.drive_close;
	assign busy_res     = res_s2.busy_res;
	assign done_res     = res_s2.done_res;
	assign outcome      = res_s2.outcome;

	// The bridge is never driven both ways at once
	a_no_shoot_through: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.drive_open && res_s2.drive_close))
		else $error("both drive lines high");

	// Drive lines only with the driver awake
	a_drive_awake: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.drive_open || res_s2.drive_close) |-> res_s2.driver_awake)
		else $error("drive without driver awake");

	// A finished operation leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done_res |-> !res_s2.busy_res)
		else $error("done while still busy");

	// With the result register empty the input side never stalls
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result register");

endmodule
